// ===== hdl/gpce_pkg.sv =====
// Package: shared types and constants for the gamepad report change-event core.
`timescale 1ns / 1ps
package gpce_pkg;

    localparam int MAPPED_BUTTONS = 20;
    localparam int AXIS_COUNT     = 6;
    localparam int STICK_COUNT    = 4;
    localparam int EVENT_SLOTS    = MAPPED_BUTTONS + AXIS_COUNT;
    localparam int FIFO_DEPTH     = 2;

    localparam logic [14:0] DEADZONE_RESET = 15'd2500;

    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_AXIS   = 1'b1;

    localparam logic REG_DEADZONE = 1'b0;

    localparam logic signed [15:0] STICK_MIN = 16'sh8000;
    localparam logic signed [15:0] STICK_MAX = 16'sh7FFF;
    localparam logic [14:0]        TRIG_MAX  = 15'h7FFF;

    // button scan order: source word (0 low, 1 high) and bit position
    localparam logic BTN_WORD [0:MAPPED_BUTTONS-1] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
    };
    localparam logic [4:0] BTN_BIT [0:MAPPED_BUTTONS-1] = '{
        5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd22, 5'd26, 5'd9,  5'd10, 5'd18
    };

    typedef struct packed {
        logic [MAPPED_BUTTONS-1:0]         btn_chg;
        logic [MAPPED_BUTTONS-1:0]         btn_new;
        logic [AXIS_COUNT-1:0]             ax_chg;
        logic [AXIS_COUNT-1:0][15:0]       ax_val;
        logic [62:0]                       stamp;
    } t_entry;

endpackage

// ===== hdl/gpce_front.sv =====
// Front end: accepts reports, tracks previous state and builds change entries.
`timescale 1ns / 1ps
module gpce_front #(
    parameter int SCAN_COUNT = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [14:0]          i_deadzone,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_packet_number,
    input  logic [31:0]          i_buttons_low,
    input  logic [31:0]          i_buttons_high,
    input  logic signed [15:0]   i_left_x,
    input  logic signed [15:0]   i_left_y,
    input  logic signed [15:0]   i_right_x,
    input  logic signed [15:0]   i_right_y,
    input  logic [15:0]          i_trigger_left,
    input  logic [15:0]          i_trigger_right,
    input  logic [62:0]          i_timestamp,
    input  logic                 i_full,
    output logic                 o_push,
    output gpce_pkg::t_entry     o_entry
);
    import gpce_pkg::*;

    logic [31:0]            r_prev_packet;
    logic [SCAN_COUNT-1:0]  r_prev_btn;
    logic signed [15:0]     r_prev_stick [STICK_COUNT];
    logic [14:0]            r_prev_trig [2];

    logic                      accept;
    logic                      new_pkt;
    logic [MAPPED_BUTTONS-1:0] nb;
    logic [MAPPED_BUTTONS-1:0] chg;
    logic signed [15:0]        stick_in [STICK_COUNT];
    logic signed [15:0]        stick_cond [STICK_COUNT];
    logic [15:0]               trig_in [2];
    logic [14:0]               trig_cond [2];
    logic [AXIS_COUNT-1:0]     ax_chg;
    logic [AXIS_COUNT-1:0][15:0] ax_val;
    logic signed [16:0]        dz;

    assign stick_in[0] = i_left_x;
    assign stick_in[1] = i_left_y;
    assign stick_in[2] = i_right_x;
    assign stick_in[3] = i_right_y;
    assign trig_in[0]  = i_trigger_left;
    assign trig_in[1]  = i_trigger_right;
    assign dz          = $signed({2'b00, i_deadzone});

    assign o_in_stall = i_full;
    assign accept     = i_in_valid & ~i_full;
    assign new_pkt    = (i_packet_number != r_prev_packet);

    genvar g;
    generate
        for (g = 0; g < MAPPED_BUTTONS; g++) begin : g_btn
            if (g < SCAN_COUNT) begin : g_scan
                assign nb[g]  = BTN_WORD[g] ? i_buttons_high[BTN_BIT[g]]
                                            : i_buttons_low[BTN_BIT[g]];
                assign chg[g] = nb[g] ^ r_prev_btn[g];
            end else begin : g_off
                assign nb[g]  = 1'b0;
                assign chg[g] = 1'b0;
            end
        end

        for (g = 0; g < STICK_COUNT; g++) begin : g_stick
            logic signed [16:0] v;
            assign v = 17'(stick_in[g]);
            assign stick_cond[g] = ((v > -dz) && (v < dz)) ? 16'sd0 : stick_in[g];
            assign ax_chg[g] = (stick_cond[g] != r_prev_stick[g]);
            if (g % 2 == 1) begin : g_neg
                assign ax_val[g] = (stick_cond[g] == STICK_MIN) ? STICK_MAX
                                                                 : -stick_cond[g];
            end else begin : g_pos
                assign ax_val[g] = stick_cond[g];
            end
        end

        for (g = 0; g < 2; g++) begin : g_trig
            assign trig_cond[g] = trig_in[g][15] ? TRIG_MAX : trig_in[g][14:0];
            assign ax_chg[STICK_COUNT+g] = (trig_cond[g] != r_prev_trig[g]);
            assign ax_val[STICK_COUNT+g] = {1'b0, trig_cond[g]};
        end
    endgenerate

    assign o_entry.btn_chg = chg;
    assign o_entry.btn_new = nb;
    assign o_entry.ax_chg  = ax_chg;
    assign o_entry.ax_val  = ax_val;
    assign o_entry.stamp   = i_timestamp;
    assign o_push          = accept & new_pkt & ((|chg) | (|ax_chg));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_packet <= '0;
            r_prev_btn    <= '0;
            for (int k = 0; k < STICK_COUNT; k++) r_prev_stick[k] <= '0;
            r_prev_trig[0] <= '0;
            r_prev_trig[1] <= '0;
        end else if (accept && new_pkt) begin
            r_prev_packet <= i_packet_number;
            r_prev_btn    <= nb[SCAN_COUNT-1:0];
            for (int k = 0; k < STICK_COUNT; k++) r_prev_stick[k] <= stick_cond[k];
            r_prev_trig[0] <= trig_cond[0];
            r_prev_trig[1] <= trig_cond[1];
        end
    end

endmodule

// ===== hdl/gpce_fifo.sv =====
// Two-entry queue between front end and event serializer.
`timescale 1ns / 1ps
module gpce_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gpce_pkg::t_entry   i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output gpce_pkg::t_entry   o_entry
);
    import gpce_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_entry                 r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [PTR_W:0]         r_count;

    assign o_full  = (r_count == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/gpce_back.sv =====
// Back end: serializes one queued entry into events, lowest slot first.
`timescale 1ns / 1ps
module gpce_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  gpce_pkg::t_entry     i_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_event_kind,
    output logic [4:0]           o_event_code,
    output logic                 o_pressed,
    output logic signed [15:0]   o_axis_value,
    output logic [62:0]          o_event_time,
    output logic                 o_last_of_run
);
    import gpce_pkg::*;

    logic [EVENT_SLOTS-1:0]          r_pend;
    logic [MAPPED_BUTTONS-1:0]       r_btn_new;
    logic [AXIS_COUNT-1:0][15:0]     r_ax_val;
    logic [62:0]                     r_stamp;

    logic                  r_out_valid;
    logic                  r_kind;
    logic [4:0]            r_code;
    logic                  r_pressed;
    logic signed [15:0]    r_value;
    logic [62:0]           r_time;
    logic                  r_last;

    logic                  busy;
    logic                  out_load;
    logic                  emit;
    logic [4:0]            idx;
    logic                  kind;
    logic [2:0]            ax_idx;
    logic [EVENT_SLOTS-1:0] rest;

    assign busy     = |r_pend;
    assign out_load = ~r_out_valid | ~i_out_stall;
    assign emit     = busy & out_load;
    assign o_pop    = ~busy & ~i_empty;
    assign rest     = r_pend & (r_pend - 1'b1);

    always_comb begin
        idx = '0;
        for (int k = EVENT_SLOTS - 1; k >= 0; k--) begin
            if (r_pend[k]) idx = 5'(k);
        end
    end

    assign kind   = (idx >= 5'(MAPPED_BUTTONS)) ? KIND_AXIS : KIND_BUTTON;
    assign ax_idx = 3'(idx - 5'(MAPPED_BUTTONS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (o_pop) begin
            r_pend <= {i_entry.ax_chg, i_entry.btn_chg};
        end else if (emit) begin
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_btn_new <= i_entry.btn_new;
            r_ax_val  <= i_entry.ax_val;
            r_stamp   <= i_entry.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= kind;
            r_time <= r_stamp;
            r_last <= (rest == '0);
            if (kind == KIND_AXIS) begin
                r_code    <= {2'b00, ax_idx};
                r_pressed <= 1'b0;
                r_value   <= r_ax_val[ax_idx];
            end else begin
                r_code    <= idx;
                r_pressed <= r_btn_new[idx];
                r_value   <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_event_code  = r_code;
    assign o_pressed     = r_pressed;
    assign o_axis_value  = r_value;
    assign o_event_time  = r_time;
    assign o_last_of_run = r_last;

endmodule

// ===== hdl/gamepad_report_change_events_core.sv =====
// With the serializer idle, an accepted report is queued, popped into the pending register,
// and its first event is then registered onto the output. Throughput: one event per cycle while
// i_out_stall is low; a report is popped only once all events of the previous one are emitted,
// and a two-entry queue decouples input from it. Dropped or unchanged reports emit nothing.
// Reset (synchronous, active low): previous state zero, deadzone 2500, queue empty.
`timescale 1ns / 1ps
module gamepad_report_change_events_core #(
    parameter int BUTTON_COUNT = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_packet_number,
    input  logic [31:0]          i_buttons_low,
    input  logic [31:0]          i_buttons_high,
    input  logic signed [15:0]   i_left_x,
    input  logic signed [15:0]   i_left_y,
    input  logic signed [15:0]   i_right_x,
    input  logic signed [15:0]   i_right_y,
    input  logic [15:0]          i_trigger_left,
    input  logic [15:0]          i_trigger_right,
    input  logic [62:0]          i_timestamp,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_event_kind,
    output logic [4:0]           o_event_code,
    output logic                 o_pressed,
    output logic signed [15:0]   o_axis_value,
    output logic [62:0]          o_event_time,
    output logic                 o_last_of_run
);
    import gpce_pkg::*;

    localparam int SCAN_COUNT = (BUTTON_COUNT < MAPPED_BUTTONS) ? BUTTON_COUNT
                                                                : MAPPED_BUTTONS;

    logic [14:0] r_deadzone;
    logic        cfg_write;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_entry      push_entry;
    t_entry      head_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_DEADZONE) ? {17'd0, r_deadzone} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DEADZONE_RESET;
        end else if (cfg_write && paddr[2] == REG_DEADZONE) begin
            r_deadzone <= pwdata[14:0];
        end
    end

    gpce_front #(
        .SCAN_COUNT (SCAN_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_deadzone      (r_deadzone),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_packet_number (i_packet_number),
        .i_buttons_low   (i_buttons_low),
        .i_buttons_high  (i_buttons_high),
        .i_left_x        (i_left_x),
        .i_left_y        (i_left_y),
        .i_right_x       (i_right_x),
        .i_right_y       (i_right_y),
        .i_trigger_left  (i_trigger_left),
        .i_trigger_right (i_trigger_right),
        .i_timestamp     (i_timestamp),
        .i_full          (full),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    gpce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    gpce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_event_code  (o_event_code),
        .o_pressed     (o_pressed),
        .o_axis_value  (o_axis_value),
        .o_event_time  (o_event_time),
        .o_last_of_run (o_last_of_run)
    );

endmodule
